// ===== src/msa_pkg.sv =====
package msa_pkg;

   localparam int SLOT_COUNT_DEF  = 16;
   localparam int BASE_VECTOR_DEF = 80;
   localparam int MAX_RESULTS     = 16;
   localparam int REL_CNT_W       = 5;

   localparam logic [3:0] TAG_MARK = 4'hD;
   localparam logic [7:0] CAP_MIN  = 8'h40;

   localparam logic MODE_CONFIGURE = 1'b0;
   localparam logic MODE_RELEASE   = 1'b1;

   typedef enum logic [2:0] {
      STAT_CONFIGURED = 3'd0,
      STAT_REJECTED   = 3'd1,
      STAT_FULL       = 3'd2,
      STAT_RELEASED   = 3'd3,
      STAT_NONE       = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        mode;
      logic [63:0] process_id;
      logic [63:0] resource_id;
      logic        resource_is_msi;
      logic [63:0] resource_owner;
      logic [63:0] device_tag;
      logic [7:0]  cap_pointer;
   } req_type;

   typedef struct packed {
      logic [63:0] owner;
      logic [63:0] resource;
      logic [7:0]  bus;
      logic [4:0]  device;
      logic [2:0]  func;
      logic [7:0]  cap;
   } slot_rec_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  vector;
      logic [7:0]  bus;
      logic [4:0]  device;
      logic [2:0]  func;
      logic [7:0]  cap;
      logic        last;
   } rsp_type;

endpackage

// ===== src/msi_vector_slot_allocator_top.sv =====
// A rejected configure request goes from idle straight to the finish state; any other
// request walks the slot table one slot per cycle through the table memory's read port,
// and one request is in work at a time. A release request gives one result per freed
// slot as the walk finds them (at most MAX_RESULTS), or one STAT_NONE result if none.
// Results show for one cycle on rsp_strobe; the receiver cannot stall.
// Reset clears all slot active bits; slot contents stay unwritten until configured.
module msi_vector_slot_allocator_top #(
   parameter int SLOT_COUNT  = msa_pkg::SLOT_COUNT_DEF,
   parameter int BASE_VECTOR = msa_pkg::BASE_VECTOR_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [63:0] req_process_id,
   input  logic [63:0] req_resource_id,
   input  logic        req_resource_is_msi,
   input  logic [63:0] req_resource_owner,
   input  logic [63:0] req_device_tag,
   input  logic [7:0]  req_cap_pointer,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_vector,
   output logic [7:0]  rsp_bus,
   output logic [4:0]  rsp_device,
   output logic [2:0]  rsp_function_res,
   output logic [7:0]  rsp_cap_offset,
   output logic        rsp_last
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   msa_pkg::req_type      req;
   msa_pkg::slot_rec_type ram_wr_data;
   msa_pkg::slot_rec_type ram_rd_data;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic                  emit_vld;
   msa_pkg::rsp_type      emit;
   logic                  strobe_ff;
   msa_pkg::rsp_type      rsp_ff;

   assign req = '{mode: req_mode, process_id: req_process_id,
                  resource_id: req_resource_id, resource_is_msi: req_resource_is_msi,
                  resource_owner: req_resource_owner, device_tag: req_device_tag,
                  cap_pointer: req_cap_pointer};

   msa_slot_ram #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   msa_seq #(
      .SLOT_COUNT  (SLOT_COUNT),
      .BASE_VECTOR (BASE_VECTOR)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req),
      .busy        (busy),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .emit_vld    (emit_vld),
      .emit        (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= emit_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_vld) begin
         rsp_ff <= emit;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_vector       = rsp_ff.vector;
   assign rsp_bus          = rsp_ff.bus;
   assign rsp_device       = rsp_ff.device;
   assign rsp_function_res = rsp_ff.func;
   assign rsp_cap_offset   = rsp_ff.cap;
   assign rsp_last         = rsp_ff.last;

`ifndef ASSERT_OFF
   a_rsp_needs_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a request in work");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not start");

   a_not_last_release: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> rsp_status == msa_pkg::STAT_RELEASED)
      else $error("non-final result outside a release");

   a_table_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> busy && !emit.last == 1'b0)
      else $error("table write outside a configure finish");
`endif

endmodule

// ===== src/msa_slot_ram.sv =====
module msa_slot_ram #(
   parameter int SLOT_COUNT = msa_pkg::SLOT_COUNT_DEF,
   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  msa_pkg::slot_rec_type wr_data,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output msa_pkg::slot_rec_type rd_data
);

   msa_pkg::slot_rec_type mem [SLOT_COUNT];
   msa_pkg::slot_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/msa_seq.sv =====
module msa_seq #(
   parameter int SLOT_COUNT  = msa_pkg::SLOT_COUNT_DEF,
   parameter int BASE_VECTOR = msa_pkg::BASE_VECTOR_DEF,
   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
   localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  msa_pkg::req_type      req,
   output logic                  busy,
   output logic                  ram_wr_en,
   output logic [IDX_W-1:0]      ram_wr_addr,
   output msa_pkg::slot_rec_type ram_wr_data,
   output logic                  ram_rd_en,
   output logic [IDX_W-1:0]      ram_rd_addr,
   input  msa_pkg::slot_rec_type ram_rd_data,
   output logic                  emit_vld,
   output msa_pkg::rsp_type      emit
);

   msa_pkg::state_type state_ff, state_in;
   logic [SLOT_COUNT-1:0] active_ff, active_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in, rd_cnt_nxt;
   logic issue_ff, issue_in;
   logic cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic rej_ff, rej_in;
   logic found_ff, found_in;
   logic [IDX_W-1:0] pick_ff, pick_in;
   logic free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic pend_vld_ff, pend_vld_in;
   msa_pkg::rsp_type pend_ff, pend_in;
   logic [msa_pkg::REL_CNT_W-1:0] rel_cnt_ff, rel_cnt_in;

   logic mode_ff;
   logic [63:0] pid_ff;
   logic [63:0] rid_ff;
   logic [7:0] bus_ff;
   logic [4:0] dev_ff;
   logic [2:0] fn_ff;
   logic [7:0] cap_ff;

   logic accept;
   logic req_ok;
   logic slot_act;
   logic own_hit;
   logic [IDX_W-1:0] wr_idx;

   function automatic logic [7:0] vec_of(input logic [IDX_W-1:0] idx);
      vec_of = 8'(BASE_VECTOR) + 8'(idx);
   endfunction

   assign busy   = (state_ff != msa_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign req_ok = req.resource_is_msi && (req.resource_owner == req.process_id) &&
                   (req.device_tag[63:60] == msa_pkg::TAG_MARK) &&
                   (req.cap_pointer >= msa_pkg::CAP_MIN);

   assign rd_cnt_nxt = rd_cnt_ff + CNT_W'(1);
   assign slot_act   = active_ff[cmp_idx_ff];
   assign own_hit    = slot_act && (ram_rd_data.owner == pid_ff);
   assign wr_idx     = found_ff ? pick_ff : free_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= msa_pkg::ST_IDLE;
         active_ff     <= '0;
         rd_cnt_ff     <= '0;
         issue_ff      <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         rej_ff        <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rel_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         rd_cnt_ff     <= rd_cnt_in;
         issue_ff      <= issue_in;
         cmp_vld_ff    <= cmp_vld_in;
         rej_ff        <= rej_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         pend_vld_ff   <= pend_vld_in;
         rel_cnt_ff    <= rel_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      pick_ff     <= pick_in;
      free_idx_ff <= free_idx_in;
      pend_ff     <= pend_in;
      if (accept) begin
         mode_ff <= req.mode;
         pid_ff  <= req.process_id;
         rid_ff  <= req.resource_id;
         bus_ff  <= req.device_tag[15:8];
         dev_ff  <= req.device_tag[7:3];
         fn_ff   <= req.device_tag[2:0];
         cap_ff  <= req.cap_pointer;
      end
   end

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      rd_cnt_in     = rd_cnt_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      rej_in        = rej_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      pend_vld_in   = pend_vld_ff;
      pend_in       = pend_ff;
      rel_cnt_in    = rel_cnt_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wr_idx;
      ram_wr_data   = '{owner: pid_ff, resource: rid_ff, bus: bus_ff, device: dev_ff,
                        func: fn_ff, cap: cap_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rd_cnt_ff[IDX_W-1:0];
      emit_vld      = 1'b0;
      emit          = '{status: msa_pkg::STAT_NONE, vector: 8'd0, bus: 8'd0, device: 5'd0,
                        func: 3'd0, cap: 8'd0, last: 1'b1};

      case (state_ff)
         msa_pkg::ST_IDLE: begin
            if (accept) begin
               rd_cnt_in     = '0;
               issue_in      = 1'b1;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               pend_vld_in   = 1'b0;
               rel_cnt_in    = '0;
               rej_in        = (req.mode == msa_pkg::MODE_CONFIGURE) && !req_ok;
               state_in      = rej_in ? msa_pkg::ST_FINISH : msa_pkg::ST_WALK;
            end
         end

         msa_pkg::ST_WALK: begin
            // issue the next read while comparing the one returned
            if (issue_ff) begin
               ram_rd_en  = 1'b1;
               rd_cnt_in  = rd_cnt_nxt;
               issue_in   = (rd_cnt_nxt != CNT_W'(SLOT_COUNT));
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_cnt_ff[IDX_W-1:0];
            end
            if (cmp_vld_ff) begin
               if (!issue_ff) begin
                  state_in = msa_pkg::ST_FINISH;
               end
               if (mode_ff == msa_pkg::MODE_CONFIGURE) begin
                  if (own_hit && (ram_rd_data.resource == rid_ff)) begin
                     found_in   = 1'b1;
                     pick_in    = cmp_idx_ff;
                     state_in   = msa_pkg::ST_FINISH;
                     issue_in   = 1'b0;
                     cmp_vld_in = 1'b0;
                  end else if (!slot_act && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = cmp_idx_ff;
                  end
               end else if (own_hit) begin
                  active_in[cmp_idx_ff] = 1'b0;
                  // flush the previous freed slot; it is not the final one
                  if (pend_vld_ff) begin
                     emit_vld = 1'b1;
                     emit     = pend_ff;
                  end
                  pend_vld_in = 1'b1;
                  pend_in     = '{status: msa_pkg::STAT_RELEASED, vector: vec_of(cmp_idx_ff),
                                  bus: ram_rd_data.bus, device: ram_rd_data.device,
                                  func: ram_rd_data.func, cap: ram_rd_data.cap,
                                  last: 1'b0};
                  rel_cnt_in  = rel_cnt_ff + msa_pkg::REL_CNT_W'(1);
                  if (rel_cnt_ff == msa_pkg::REL_CNT_W'(msa_pkg::MAX_RESULTS - 1)) begin
                     state_in   = msa_pkg::ST_FINISH;
                     issue_in   = 1'b0;
                     cmp_vld_in = 1'b0;
                  end
               end
            end
         end

         msa_pkg::ST_FINISH: begin
            emit_vld = 1'b1;
            state_in = msa_pkg::ST_IDLE;
            issue_in = 1'b0;
            if (mode_ff == msa_pkg::MODE_RELEASE) begin
               if (pend_vld_ff) begin
                  emit      = pend_ff;
                  emit.last = 1'b1;
               end
               pend_vld_in = 1'b0;
            end else if (rej_ff) begin
               emit.status = msa_pkg::STAT_REJECTED;
            end else if (found_ff || free_found_ff) begin
               ram_wr_en         = 1'b1;
               active_in[wr_idx] = 1'b1;
               emit = '{status: msa_pkg::STAT_CONFIGURED, vector: vec_of(wr_idx),
                        bus: bus_ff, device: dev_ff, func: fn_ff, cap: cap_ff, last: 1'b1};
            end else begin
               emit.status = msa_pkg::STAT_FULL;
            end
         end

         default: begin
            state_in = msa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import msa_pkg::*;

   localparam int SLOT_COUNT  = 16;
   localparam int BASE_VECTOR = 80;
   localparam int RANDOM_ITEMS = 430;
   localparam int TAIL_CYCLES = SLOT_COUNT + 8;
   localparam int DRAIN_LIMIT = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = MODE_CONFIGURE;
   logic [63:0] req_process_id = '0;
   logic [63:0] req_resource_id = '0;
   logic        req_resource_is_msi = 1'b0;
   logic [63:0] req_resource_owner = '0;
   logic [63:0] req_device_tag = '0;
   logic [7:0]  req_cap_pointer = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_vector;
   logic [7:0]  rsp_bus;
   logic [4:0]  rsp_device;
   logic [2:0]  rsp_function_res;
   logic [7:0]  rsp_cap_offset;
   logic        rsp_last;

   // predicted copy of the slot table
   logic         tbl_active [SLOT_COUNT];
   slot_rec_type tbl_rec    [SLOT_COUNT];

   rsp_type slot_results_due[$];
   int      mismatch_count = 0;

   msi_vector_slot_allocator_top #(
      .SLOT_COUNT (SLOT_COUNT),
      .BASE_VECTOR(BASE_VECTOR)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_process_id     (req_process_id),
      .req_resource_id    (req_resource_id),
      .req_resource_is_msi(req_resource_is_msi),
      .req_resource_owner (req_resource_owner),
      .req_device_tag     (req_device_tag),
      .req_cap_pointer    (req_cap_pointer),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_vector         (rsp_vector),
      .rsp_bus            (rsp_bus),
      .rsp_device         (rsp_device),
      .rsp_function_res   (rsp_function_res),
      .rsp_cap_offset     (rsp_cap_offset),
      .rsp_last           (rsp_last)
   );

   always #6 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR at %0t ns: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic rsp_type make_rsp(input status_type st, input logic [7:0] vec,
                                        input logic [7:0] bus, input logic [4:0] dev,
                                        input logic [2:0] fn, input logic [7:0] cap,
                                        input logic lst);
      rsp_type r;
      r.status = st;
      r.vector = vec;
      r.bus    = bus;
      r.device = dev;
      r.func   = fn;
      r.cap    = cap;
      r.last   = lst;
      return r;
   endfunction

   function automatic logic [7:0] vector_of(input int idx);
      return 8'(BASE_VECTOR + idx);
   endfunction

   task automatic predict_slots(input req_type r);
      int       pick;
      int       freed;
      bit       ok;
      rsp_type  tail;
      if (r.mode == MODE_RELEASE) begin
         freed = 0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (freed < MAX_RESULTS && tbl_active[i] && tbl_rec[i].owner == r.process_id) begin
               slot_results_due.push_back(make_rsp(STAT_RELEASED, vector_of(i), tbl_rec[i].bus,
                                                   tbl_rec[i].device, tbl_rec[i].func,
                                                   tbl_rec[i].cap, 1'b0));
               tbl_active[i] = 1'b0;
               freed++;
            end
         end
         if (freed == 0) begin
            slot_results_due.push_back(make_rsp(STAT_NONE, '0, '0, '0, '0, '0, 1'b1));
         end else begin
            // mark the final freed slot
            tail = slot_results_due.pop_back();
            tail.last = 1'b1;
            slot_results_due.push_back(tail);
         end
      end else begin
         ok = r.resource_is_msi && (r.resource_owner == r.process_id) &&
              (r.device_tag[63:60] == TAG_MARK) && (r.cap_pointer >= CAP_MIN);
         if (!ok) begin
            slot_results_due.push_back(make_rsp(STAT_REJECTED, '0, '0, '0, '0, '0, 1'b1));
         end else begin
            pick = SLOT_COUNT;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (pick == SLOT_COUNT && tbl_active[i] && tbl_rec[i].owner == r.process_id &&
                   tbl_rec[i].resource == r.resource_id)
                  pick = i;
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (pick == SLOT_COUNT && !tbl_active[i])
                  pick = i;
            end
            if (pick == SLOT_COUNT) begin
               slot_results_due.push_back(make_rsp(STAT_FULL, '0, '0, '0, '0, '0, 1'b1));
            end else begin
               tbl_active[pick]       = 1'b1;
               tbl_rec[pick].owner    = r.process_id;
               tbl_rec[pick].resource = r.resource_id;
               tbl_rec[pick].bus      = r.device_tag[15:8];
               tbl_rec[pick].device   = r.device_tag[7:3];
               tbl_rec[pick].func     = r.device_tag[2:0];
               tbl_rec[pick].cap      = r.cap_pointer;
               slot_results_due.push_back(make_rsp(STAT_CONFIGURED, vector_of(pick),
                                                   tbl_rec[pick].bus, tbl_rec[pick].device,
                                                   tbl_rec[pick].func, tbl_rec[pick].cap, 1'b1));
            end
         end
      end
   endtask

   // results are sampled at the edge that ends their cycle
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (slot_results_due.size() == 0) begin
            report_mismatch("unexpected result, status", 64'(rsp_status), 64'd0);
         end else begin
            want = slot_results_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_vector !== want.vector)
               report_mismatch("vector", 64'(rsp_vector), 64'(want.vector));
            if (rsp_bus !== want.bus)
               report_mismatch("bus", 64'(rsp_bus), 64'(want.bus));
            if (rsp_device !== want.device)
               report_mismatch("device", 64'(rsp_device), 64'(want.device));
            if (rsp_function_res !== want.func)
               report_mismatch("function_res", 64'(rsp_function_res), 64'(want.func));
            if (rsp_cap_offset !== want.cap)
               report_mismatch("cap_offset", 64'(rsp_cap_offset), 64'(want.cap));
            if (rsp_last !== want.last)
               report_mismatch("last", 64'(rsp_last), 64'(want.last));
         end
      end
   end

   // start stays high on return so a following request can go back to back
   task automatic issue_request(input req_type r);
      start               <= 1'b1;
      req_mode            <= r.mode;
      req_process_id      <= r.process_id;
      req_resource_id     <= r.resource_id;
      req_resource_is_msi <= r.resource_is_msi;
      req_resource_owner  <= r.resource_owner;
      req_device_tag      <= r.device_tag;
      req_cap_pointer     <= r.cap_pointer;
      do @(posedge clock); while (busy);
      predict_slots(r);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_results_drained();
      start <= 1'b0;
      while (slot_results_due.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_config(input logic [63:0] pid, input logic [63:0] rid,
                                           input logic msi, input logic [63:0] owner,
                                           input logic [63:0] tag, input logic [7:0] cap);
      req_type r;
      r.mode            = MODE_CONFIGURE;
      r.process_id      = pid;
      r.resource_id     = rid;
      r.resource_is_msi = msi;
      r.resource_owner  = owner;
      r.device_tag      = tag;
      r.cap_pointer     = cap;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type make_release(input logic [63:0] pid);
      req_type r;
      r = make_config(pid, rand64(), 1'($urandom), rand64(), rand64(), 8'($urandom));
      r.mode = MODE_RELEASE;
      return r;
   endfunction

   function automatic logic [63:0] good_tag();
      return {TAG_MARK, 28'($urandom), $urandom};
   endfunction

   task automatic test_release_empty();
      issue_request(make_release('0));
   endtask

   task automatic test_rejects();
      logic [63:0] pid;
      logic [63:0] tag;
      pid = 64'h0123_4567_89AB_CDEF;
      tag = 64'hD000_0000_0000_ABCD;
      issue_request(make_config(pid, 64'h1, 1'b0, pid, tag, 8'h80));
      issue_request(make_config(pid, 64'h1, 1'b1, pid ^ 64'h1, tag, 8'h80));
      issue_request(make_config(pid, 64'h1, 1'b1, pid, 64'hC000_0000_0000_ABCD, 8'h80));
      issue_request(make_config(pid, 64'h1, 1'b1, pid, 64'h0FFF_FFFF_FFFF_FFFF, 8'hFF));
      issue_request(make_config(pid, 64'h1, 1'b1, pid, tag, 8'h3F));
      // every check fails at once
      issue_request(make_config(pid, 64'h1, 1'b0, ~pid, 64'hE000_0000_0000_0000, 8'h00));
   endtask

   task automatic test_configure_extremes();
      issue_request(make_config('1, '1, 1'b1, '1, 64'hDFFF_FFFF_FFFF_FFFF, 8'hFF));
      issue_request(make_config('0, '0, 1'b1, '0, 64'hD000_0000_0000_0000, 8'h40));
      // same process and resource: reuse the slot with new device fields
      issue_request(make_config('1, '1, 1'b1, '1, 64'hD000_0000_0000_1234, 8'h80));
      issue_request(make_config('1, '0, 1'b1, '1, 64'hD555_5555_5555_55AA, 8'hC1));
      issue_request(make_release('1));
   endtask

   task automatic test_table_full();
      logic [63:0] pid;
      pid = 64'hFEDC_BA98_7654_3210;
      for (int k = 0; k < SLOT_COUNT; k++)
         issue_request(make_config(pid, 64'(100 + k), 1'b1, pid, good_tag(),
                                   8'($urandom_range(8'h40, 8'hFF))));
      // validation wins over the full table
      issue_request(make_config(pid, 64'h999, 1'b1, pid, good_tag(), 8'h10));
      issue_request(make_config(pid, 64'(100), 1'b1, pid, good_tag(), 8'h55));
      issue_request(make_release(pid));
      issue_request(make_release('0));
   endtask

   task automatic test_random();
      logic [63:0] pid_pool [4];
      logic [63:0] rid_pool [20];
      logic [63:0] pid;
      logic [63:0] tag;
      logic [3:0]  nib;
      req_type     r;
      int          pick;
      int          fault;
      pid_pool[0] = '1;
      pid_pool[1] = '0;
      pid_pool[2] = rand64();
      pid_pool[3] = rand64();
      foreach (rid_pool[i]) rid_pool[i] = rand64();
      rid_pool[0] = '0;
      rid_pool[1] = '1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3)
            wait_results_drained();
         // one long stretch with no gaps
         if ((n < 200 || n >= 300) && $urandom_range(0, 99) < 15)
            idle_cycles($urandom_range(1, 20));
         pid = ($urandom_range(0, 9) == 0) ? rand64() : pid_pool[$urandom_range(0, 3)];
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            r = make_release(pid);
         end else begin
            r = make_config(pid, rid_pool[$urandom_range(0, 19)], 1'b1, pid, good_tag(),
                            8'($urandom_range(8'h40, 8'hFF)));
            if (pick >= 82) begin
               fault = $urandom_range(0, 4);
               if (fault == 0 || fault == 4)
                  r.resource_is_msi = 1'b0;
               if (fault == 1 || fault == 4)
                  r.resource_owner = rand64();
               if (fault == 2 || fault == 4) begin
                  nib = 4'($urandom_range(0, 14));
                  if (nib >= TAG_MARK) nib = nib + 4'd1;
                  r.device_tag[63:60] = nib;
               end
               if (fault == 3 || fault == 4)
                  r.cap_pointer = 8'($urandom_range(0, 8'h3F));
            end
         end
         issue_request(r);
      end
   endtask

   initial begin
      int waited;
      foreach (tbl_active[i]) tbl_active[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_release_empty();
      test_rejects();
      test_configure_extremes();
      test_table_full();
      test_random();
      start <= 1'b0;
      waited = 0;
      while (slot_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (slot_results_due.size() != 0)
         report_mismatch("results never delivered, count", 64'(slot_results_due.size()),
                         64'd0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
